FILE: rtl/rlwr_pkg.sv
package rlwr_pkg;

  // Row geometry and field widths
  localparam int unsigned MAX_ROW_WIDTH = 1024;
  localparam int unsigned COL_W         = 11;

  // Last column index plus one, as a column-wide value
  localparam logic [COL_W-1:0] ROW_LIMIT = COL_W'(MAX_ROW_WIDTH);

  // Reset value of the minimum feature size register
  localparam logic [COL_W-1:0] MIN_FEATURE_RESET = COL_W'(45);

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = 3 * COL_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // One pixel request
  typedef struct packed {
    logic white;
    logic last;
  } pixel_t;

  // One row result
  typedef struct packed {
    logic             found;
    logic [COL_W-1:0] trailing;
    logic [COL_W-1:0] length;
    logic [COL_W-1:0] start;
  } result_t;

endpackage

FILE: rtl/row_longest_white_run_unit.sv
// The request carrying tlast is held in the input register; once the result register
// has room, the row result is loaded there and offered. Throughput: one pixel per cycle
// while no row-end pixel waits for room; the per-pixel update is one compare and increment
// between the input register and the result register. A full result register with a
// stalled consumer holds back only the row-end pixel. Reset (rst_ni low, asynchronous):
// both stages empty, row state cleared, minimum run threshold back to 45.
module row_longest_white_run_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write: threshold that a run length must exceed to set found
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rlwr_pkg::COL_W-1:0]       cfg_data_i,
  // Pixel stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [rlwr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // [0] pixel_white, rest zero
  input  logic                             s_axis_tlast_i,  // row_end
  // Row result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [rlwr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,  // run_start, run_length,
                                                             // trailing_black, zero fill
  output logic                             m_axis_tuser_o   // found
);

  logic [rlwr_pkg::COL_W-1:0] min_size_q;
  rlwr_pkg::pixel_t           in_pixel;
  rlwr_pkg::pixel_t           held_pixel;
  rlwr_pkg::result_t          row_result;
  rlwr_pkg::result_t          out_result;
  logic                       held_valid;
  logic                       out_room;
  logic                       step;
  logic                       s_fire;

  // Configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= rlwr_pkg::MIN_FEATURE_RESET;
    end else if (cfg_valid_i) begin
      min_size_q <= cfg_data_i;
    end
  end

  // Input handshake
  assign in_pixel.white  = s_axis_tdata_i[0];
  assign in_pixel.last   = s_axis_tlast_i;
  assign step            = held_valid && (!held_pixel.last || out_room);
  assign s_axis_tready_o = !held_valid || step;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  rlwr_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s_fire),
    .pixel_i (in_pixel),
    .drain_i (step),
    .valid_o (held_valid),
    .pixel_o (held_pixel)
  );

  rlwr_tracker u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .pixel_i    (held_pixel),
    .min_size_i (min_size_q),
    .result_o   (row_result)
  );

  rlwr_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step && held_pixel.last),
    .result_i (row_result),
    .ready_i  (m_axis_tready_i),
    .room_o   (out_room),
    .valid_o  (m_axis_tvalid_o),
    .result_o (out_result)
  );

  // Pack the result fields, lowest field first
  assign m_axis_tdata_o = {{rlwr_pkg::OUT_PAD_W{1'b0}}, out_result.trailing,
                           out_result.length, out_result.start};
  assign m_axis_tuser_o = out_result.found;

endmodule

FILE: rtl/rlwr_in_stage.sv
module rlwr_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  rlwr_pkg::pixel_t pixel_i,
  input  logic            drain_i,
  output logic            valid_o,
  output rlwr_pkg::pixel_t pixel_o
);

  logic             valid_q, valid_d;
  rlwr_pkg::pixel_t pixel_q;

  // Fill on a new request, empty when the tracker takes the held pixel
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pixel_q <= pixel_i;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

FILE: rtl/rlwr_tracker.sv
module rlwr_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  rlwr_pkg::pixel_t             pixel_i,
  input  logic [rlwr_pkg::COL_W-1:0]   min_size_i,
  output rlwr_pkg::result_t            result_o
);

  logic [rlwr_pkg::COL_W-1:0] col_q, col_d;
  logic [rlwr_pkg::COL_W-1:0] cur_start_q, cur_start_d;
  logic [rlwr_pkg::COL_W-1:0] cur_len_q, cur_len_d;
  logic                       prev_white_q, prev_white_d;
  logic [rlwr_pkg::COL_W-1:0] best_start_q, best_start_d;
  logic [rlwr_pkg::COL_W-1:0] best_len_q, best_len_d;
  logic [rlwr_pkg::COL_W-1:0] best_end_q, best_end_d;
  logic [rlwr_pkg::COL_W-1:0] col_inc;
  logic                       in_range;

  assign in_range = (col_q < rlwr_pkg::ROW_LIMIT);
  assign col_inc  = col_q + rlwr_pkg::COL_W'(1);

  // Update the run in progress and the best run with the current pixel
  always_comb begin
    col_d        = col_q;
    cur_start_d  = cur_start_q;
    cur_len_d    = cur_len_q;
    prev_white_d = prev_white_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    best_end_d   = best_end_q;
    if (in_range) begin
      if (pixel_i.white) begin
        if (prev_white_q) begin
          cur_len_d = cur_len_q + rlwr_pkg::COL_W'(1);
        end else begin
          cur_start_d = col_q;
          cur_len_d   = rlwr_pkg::COL_W'(1);
        end
        // Replace only on a strictly longer run, the earlier one wins a tie
        if (cur_len_d > best_len_q) begin
          best_start_d = cur_start_d;
          best_len_d   = cur_len_d;
          best_end_d   = col_inc;
        end
      end
      prev_white_d = pixel_i.white;
      col_d        = col_inc;
    end
  end

  // Row result from the updated state; the best run always ends inside the row
  always_comb begin
    result_o.start    = best_start_d;
    result_o.length   = best_len_d;
    result_o.trailing = col_d - best_end_d;
    result_o.found    = (best_len_d > min_size_i);
  end

  // Advance on each pixel, clear the row state after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      cur_start_q  <= '0;
      cur_len_q    <= '0;
      prev_white_q <= 1'b0;
      best_start_q <= '0;
      best_len_q   <= '0;
      best_end_q   <= '0;
    end else if (step_i) begin
      if (pixel_i.last) begin
        col_q        <= '0;
        cur_start_q  <= '0;
        cur_len_q    <= '0;
        prev_white_q <= 1'b0;
        best_start_q <= '0;
        best_len_q   <= '0;
        best_end_q   <= '0;
      end else begin
        col_q        <= col_d;
        cur_start_q  <= cur_start_d;
        cur_len_q    <= cur_len_d;
        prev_white_q <= prev_white_d;
        best_start_q <= best_start_d;
        best_len_q   <= best_len_d;
        best_end_q   <= best_end_d;
      end
    end
  end

endmodule

FILE: rtl/rlwr_out_stage.sv
module rlwr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rlwr_pkg::result_t result_i,
  input  logic              ready_i,
  output logic              room_o,
  output logic              valid_o,
  output rlwr_pkg::result_t result_o
);

  logic              valid_q, valid_d;
  rlwr_pkg::result_t result_q;

  // Room when empty or when the held result leaves this cycle
  assign room_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

FILE: rtl/rlwr_checker.sv
module rlwr_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic [rlwr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                             m_axis_tuser_o
);

  logic [rlwr_pkg::COL_W-1:0] start_w;
  logic [rlwr_pkg::COL_W-1:0] length_w;
  logic [rlwr_pkg::COL_W-1:0] trail_w;
  logic [rlwr_pkg::COL_W+1:0] span_w;

  assign start_w  = m_axis_tdata_o[rlwr_pkg::COL_W-1:0];
  assign length_w = m_axis_tdata_o[2*rlwr_pkg::COL_W-1:rlwr_pkg::COL_W];
  assign trail_w  = m_axis_tdata_o[3*rlwr_pkg::COL_W-1:2*rlwr_pkg::COL_W];
  assign span_w   = (rlwr_pkg::COL_W+2)'(start_w) + (rlwr_pkg::COL_W+2)'(length_w)
                  + (rlwr_pkg::COL_W+2)'(trail_w);

  // No result is offered when reset is first seen released
  a_reset_idle: assert property (@(posedge clk_i) $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result offered right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // Run and trailing black fit in one row
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> span_w <= (rlwr_pkg::COL_W+2)'(rlwr_pkg::MAX_ROW_WIDTH))
    else $error("row result exceeds row width");

  // A found feature has a nonzero run
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> length_w != '0)
    else $error("found set on empty run");

  // An empty run starts at column zero
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && length_w == '0 |-> start_w == '0)
    else $error("empty run with nonzero start");

endmodule

bind row_longest_white_run_unit rlwr_checker u_rlwr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: tb/sv/row_result_checker.sv
module row_result_checker
  import rlwr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [COL_W-1:0]       cfg_data_i,
  input  logic                   pix_valid_i,
  input  logic                   pix_ready_i,
  input  logic [IN_TDATA_W-1:0]  pix_data_i,   // [0] pixel_white, rest zero
  input  logic                   pix_last_i,   // row_end
  input  logic                   res_valid_i,
  input  logic                   res_ready_i,
  input  logic [OUT_TDATA_W-1:0] res_data_i,   // run_start, run_length, trailing_black, zero fill
  input  logic                   res_found_i,  // found
  output int unsigned            rows_pending_o,
  output int unsigned            fail_count_o
);

  // Shadow copy of the threshold and of the per-row run tracker
  logic [COL_W-1:0] min_size;
  logic [COL_W-1:0] col_count;
  logic [COL_W-1:0] cur_start;
  logic [COL_W-1:0] cur_len;
  logic [COL_W-1:0] best_start;
  logic [COL_W-1:0] best_len;
  logic             prev_white;

  // Row summaries still owed by the block, oldest first
  result_t row_results_q[$];

  function automatic void clear_row();
    col_count  = '0;
    cur_start  = '0;
    cur_len    = '0;
    prev_white = 1'b0;
    best_start = '0;
    best_len   = '0;
  endfunction

  // Fold one pixel into the row; at row end queue the row summary
  function automatic void advance_row(input logic white, input logic last);
    logic [COL_W:0]   used;
    logic [COL_W-1:0] trailing;
    result_t          summary;
    // Columns past the maximum width touch nothing
    if (col_count < COL_W'(MAX_ROW_WIDTH)) begin
      if (white) begin
        if (prev_white) begin
          cur_len = cur_len + 1'b1;
        end else begin
          cur_start = col_count;
          cur_len   = COL_W'(1);
        end
        // Strictly longer only, so a tie keeps the earlier run
        if (cur_len > best_len) begin
          best_start = cur_start;
          best_len   = cur_len;
        end
      end
      prev_white = white;
      col_count  = col_count + 1'b1;
    end
    if (last) begin
      used     = {1'b0, best_start} + {1'b0, best_len};
      trailing = ({1'b0, col_count} >= used) ? COL_W'({1'b0, col_count} - used) : '0;
      summary.start    = best_start;
      summary.length   = best_len;
      summary.trailing = trailing;
      summary.found    = (best_len > min_size);
      row_results_q.insert(row_results_q.size(), summary);
      clear_row();
    end
  endfunction

  // Compare one row summary against the oldest one owed
  function automatic void check_row(input result_t got);
    result_t want;
    if (row_results_q.size() == 0) begin
      $error("row summary with none pending: run_start %0d run_length %0d",
             got.start, got.length);
      fail_count_o++;
      return;
    end
    want = row_results_q.pop_front();
    if (got.start !== want.start) begin
      $error("run_start: expected %0d, got %0d", want.start, got.start);
      fail_count_o++;
    end
    if (got.length !== want.length) begin
      $error("run_length: expected %0d, got %0d", want.length, got.length);
      fail_count_o++;
    end
    if (got.trailing !== want.trailing) begin
      $error("trailing_black: expected %0d, got %0d", want.trailing, got.trailing);
      fail_count_o++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      fail_count_o++;
    end
  endfunction

  // Track every request on the three channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size = MIN_FEATURE_RESET;
      clear_row();
      row_results_q.delete();
      rows_pending_o = 0;
      fail_count_o   = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        check_row({res_found_i, res_data_i[OUT_FIELD_W-1:0]});
      end
      if (cfg_valid_i && cfg_ready_i) begin
        min_size = cfg_data_i;
      end
      if (pix_valid_i && pix_ready_i) begin
        advance_row(pix_data_i[0], pix_last_i);
      end
      rows_pending_o = row_results_q.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
module testbench;

  import rlwr_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COL_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;  // [0] pixel_white, rest zero
  logic                   s_tlast = 1'b0;  // row_end
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;  // run_start, run_length, trailing_black, zero fill
  logic                   m_tuser;  // found

  int unsigned rows_pending;
  int unsigned fail_count;

  // Receiver stall state
  int unsigned stall_left = 0;
  logic        calm = 1'b0;

  // Pixels of the row about to be sent, column order
  bit row_pixels[$];

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  row_longest_white_run_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  row_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .pix_valid_i    (s_tvalid),
    .pix_ready_i    (s_tready),
    .pix_data_i     (s_tdata),
    .pix_last_i     (s_tlast),
    .res_valid_i    (m_tvalid),
    .res_ready_i    (m_tready),
    .res_data_i     (m_tdata),
    .res_found_i    (m_tuser),
    .rows_pending_o (rows_pending),
    .fail_count_o   (fail_count)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result channel at random, with calm stretches of no stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 399) == 0) calm <= !calm;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one pixel; hold valid across back-to-back requests
  task automatic send_pixel(input bit white, input bit last, input int unsigned gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, white};
    s_tlast  <= last;
    do @(negedge clk_i); while (!s_tready);
    @(posedge clk_i);
  endtask

  // Send the staged row, row end on its last pixel
  task automatic send_row(input bit no_gaps);
    for (int i = 0; i < row_pixels.size(); i++) begin
      send_pixel(row_pixels[i], i == row_pixels.size() - 1, no_gaps ? 0 : pick_gap());
    end
  endtask

  task automatic stage_pattern(input string pattern);
    row_pixels.delete();
    for (int i = 0; i < pattern.len(); i++) begin
      row_pixels.insert(row_pixels.size(), pattern[i] == "1");
    end
  endtask

  task automatic stage_fill(input int unsigned count, input bit white);
    repeat (count) row_pixels.insert(row_pixels.size(), white);
  endtask

  // Build a row of alternating runs, with ties and long runs, or plain noise
  task automatic stage_random_row();
    int unsigned width;
    int unsigned run_len;
    int unsigned last_white_len;
    bit          color;
    row_pixels.delete();
    width = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160) : $urandom_range(1, 40);
    if ($urandom_range(0, 9) == 0) begin
      repeat (width) row_pixels.insert(row_pixels.size(), bit'($urandom_range(0, 1)));
    end else begin
      color          = bit'($urandom_range(0, 1));
      last_white_len = $urandom_range(1, 4);
      while (row_pixels.size() < width) begin
        case ($urandom_range(0, 9))
          0, 1:    run_len = last_white_len;
          2:       run_len = $urandom_range(30, 70);
          default: run_len = $urandom_range(1, 8);
        endcase
        if (color) last_white_len = run_len;
        while (run_len != 0 && row_pixels.size() < width) begin
          row_pixels.insert(row_pixels.size(), color);
          run_len--;
        end
        color = !color;
      end
    end
  endtask

  // Hold the sender until every row summary is back, then let the pipe empty
  task automatic settle_rows();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (rows_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_min_size(input logic [COL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(negedge clk_i); while (!cfg_ready);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned phase_items;
    logic [COL_W-1:0] threshold;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short rows under the reset threshold: single pixels, tie, later longer run
    stage_pattern("1");
    send_row(1'b0);
    stage_pattern("0");
    send_row(1'b0);
    stage_pattern("0110110");
    send_row(1'b0);
    stage_pattern("10111");
    send_row(1'b1);
    stage_pattern("0100");
    send_row(1'b0);
    stage_pattern("11");
    send_row(1'b1);

    // Random rows over a spread of thresholds
    for (int p = 0; p < 7; p++) begin
      if (p != 0) begin
        case (p)
          1:       threshold = '0;
          2:       threshold = '1;
          3:       threshold = COL_W'($urandom_range(1, 10));
          4:       threshold = COL_W'($urandom_range(30, 60));
          5:       threshold = COL_W'($urandom_range(0, 2047));
          default: threshold = COL_W'($urandom_range(2, 6));
        endcase
        settle_rows();
        write_min_size(threshold);
      end
      phase_items = 0;
      while (phase_items < 90) begin
        stage_random_row();
        send_row($urandom_range(0, 3) == 0);
        phase_items += row_pixels.size();
        if ($urandom_range(0, 19) == 0) settle_rows();
      end
    end

    // Overlong row: full-width white run just over the threshold, extra columns dropped
    settle_rows();
    write_min_size(COL_W'(MAX_ROW_WIDTH - 1));
    row_pixels.delete();
    stage_fill(MAX_ROW_WIDTH, 1'b1);
    stage_fill(2, 1'b0);
    stage_fill(1, 1'b1);
    send_row(1'b1);

    settle_rows();
    if (fail_count == 0) begin
      $display("** row_longest_white_run_unit: PASSED **");
    end else begin
      $display("** row_longest_white_run_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30000000;
    $display("** row_longest_white_run_unit: FAILED **");
    $finish;
  end

endmodule

FILE: row_longest_white_run_unit.f
rtl/rlwr_pkg.sv
rtl/rlwr_in_stage.sv
rtl/rlwr_tracker.sv
rtl/rlwr_out_stage.sv
rtl/row_longest_white_run_unit.sv
rtl/rlwr_checker.sv
tb/sv/row_result_checker.sv
tb/sv/testbench.sv
